[rtl/qsvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsvt_pkg
// Shared types and constants for the quadric surface voxel test.
// ----------------------------------------------------------------------------
package qsvt_pkg;

	// Field and register widths fixed by the interface
	localparam int COORD_W   = 16;
	localparam int SLOT_W    = 16;
	localparam int CFG_W     = 48;
	localparam int CONST_W   = 32;
	localparam int CFG_IDX_W = 3;

	// Clock edges from an accepted request to its result strobe
	localparam int QSVT_LATENCY = 7;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SQUARE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CROSS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CONST  = 3'd3;

	// Request: one grid point
	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
	} qsvt_req_t;

	// Result for one grid point
	typedef struct packed {
		logic on_surface;
		logic center_inside;
	} qsvt_rsp_t;

endpackage

[rtl/quadric_surface_voxel_test_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadric_surface_voxel_test_top
// Pipelined sign-change test of an implicit quadric around one grid point.
// ----------------------------------------------------------------------------
// A request (start high, busy low) is taken in every clock cycle; busy stays
// low. Each request gives exactly one result, shown on result with done high
// for one cycle, in request order. There is no back-pressure: the receiver
// must take every result as it appears. The evaluator has seven stages:
// coefficient products, gradient sums, split coordinate products, two stages
// of wide sums for the center value, the six half-voxel neighbor values and
// the final sign decision.
// Write the coefficient registers only while no request is in flight.
// ----------------------------------------------------------------------------
module quadric_surface_voxel_test_top #(
	parameter int COORD_BITS = 16,
	parameter int COEF_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  qsvt_pkg::qsvt_req_t                  req,
	output logic                                 done,
	output qsvt_pkg::qsvt_rsp_t                  result,
	input  logic                                 cfg_we,
	input  logic [qsvt_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [qsvt_pkg::CFG_W-1:0]           cfg_data
);
	import qsvt_pkg::*;

	// Working widths, all in doubled coordinates scaled by four
	localparam int CB  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int CW  = CB + 1;            // doubled coordinate
	localparam int PW  = COEF_BITS + CW;    // coefficient times coordinate
	localparam int LW  = PW + 2;            // inner Horner sum
	localparam int GW  = PW + 3;            // gradient term
	localparam int LS  = (LW + 1) / 2;      // low split of the inner sum
	localparam int HW  = LW - LS;           // high split of the inner sum
	localparam int PLW = CW + LS + 1;
	localparam int PHW = CW + HW;
	localparam int TW  = CW + LW + 1;       // one axis term of the center value
	localparam int VB  = (TW > CONST_W + 2) ? TW : CONST_W + 2;
	localparam int VW  = VB + 3;            // center value
	localparam int NW  = VW + 2;            // neighbor value

	// Configuration registers
	logic [CFG_W-1:0]   square_q;
	logic [CFG_W-1:0]   cross_q;
	logic [CFG_W-1:0]   linear_q;
	logic [CONST_W-1:0] const_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_q <= '0;
			cross_q  <= '0;
			linear_q <= '0;
			const_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SQUARE: square_q <= cfg_data;
				REG_CROSS:  cross_q  <= cfg_data;
				REG_LINEAR: linear_q <= cfg_data;
				REG_CONST:  const_q  <= cfg_data[CONST_W-1:0];
				default: ;
			endcase
		end
	end

	// Coefficient slots, low COEF_BITS bits of each slot as two's complement
	logic signed [COEF_BITS-1:0] ca, cb, cc, cd, ce, cf, cg, ch, ci;
	logic signed [CONST_W-1:0]   cj;
	logic signed [COEF_BITS-1:0] sqc [3];
	logic signed [COEF_BITS-1:0] lin [3];

	assign ca = square_q[0*SLOT_W +: COEF_BITS];
	assign cb = square_q[1*SLOT_W +: COEF_BITS];
	assign cc = square_q[2*SLOT_W +: COEF_BITS];
	assign cd = cross_q[0*SLOT_W +: COEF_BITS];
	assign ce = cross_q[1*SLOT_W +: COEF_BITS];
	assign cf = cross_q[2*SLOT_W +: COEF_BITS];
	assign cg = linear_q[0*SLOT_W +: COEF_BITS];
	assign ch = linear_q[1*SLOT_W +: COEF_BITS];
	assign ci = linear_q[2*SLOT_W +: COEF_BITS];
	assign cj = const_q;
	assign sqc[0] = ca;
	assign sqc[1] = cb;
	assign sqc[2] = cc;
	assign lin[0] = cg;
	assign lin[1] = ch;
	assign lin[2] = ci;

	// The pipeline never stalls
	assign busy = 1'b0;

	// Valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Stage 1: double the coordinates, form coefficient products
	logic signed [CB-1:0] px_c, py_c, pz_c;
	logic signed [CW-1:0] crd_c [3];
	logic signed [PW-1:0] ax_c, by_c, cz_c, dy_c, dz_c, ex_c, ez_c, fx_c, fy_c;

	assign px_c     = req.px[CB-1:0];
	assign py_c     = req.py[CB-1:0];
	assign pz_c     = req.pz[CB-1:0];
	assign crd_c[0] = {px_c, 1'b0};
	assign crd_c[1] = {py_c, 1'b0};
	assign crd_c[2] = {pz_c, 1'b0};
	assign ax_c     = ca * crd_c[0];
	assign by_c     = cb * crd_c[1];
	assign cz_c     = cc * crd_c[2];
	assign dy_c     = cd * crd_c[1];
	assign dz_c     = cd * crd_c[2];
	assign ex_c     = ce * crd_c[0];
	assign ez_c     = ce * crd_c[2];
	assign fx_c     = cf * crd_c[0];
	assign fy_c     = cf * crd_c[1];

	logic signed [CW-1:0] crd_s1 [3];
	logic signed [PW-1:0] ax_s1, by_s1, cz_s1, dy_s1, dz_s1, ex_s1, ez_s1, fx_s1, fy_s1;

	always_ff @(posedge clk) begin
		crd_s1 <= crd_c;
		ax_s1  <= ax_c;
		by_s1  <= by_c;
		cz_s1  <= cz_c;
		dy_s1  <= dy_c;
		dz_s1  <= dz_c;
		ex_s1  <= ex_c;
		ez_s1  <= ez_c;
		fx_s1  <= fx_c;
		fy_s1  <= fy_c;
	end

	// Stage 2: inner Horner sums and per-axis gradient terms
	logic signed [LW-1:0] l_c [3];
	logic signed [GW-1:0] g_c [3];

	always_comb begin
		l_c[0] = LW'(ax_s1) + LW'(fy_s1) + LW'(ez_s1) + (LW'(cg) <<< 1);
		l_c[1] = LW'(by_s1) + LW'(dz_s1) + (LW'(ch) <<< 1);
		l_c[2] = LW'(cz_s1) + (LW'(ci) <<< 1);
		g_c[0] = (GW'(ax_s1) <<< 1) + GW'(fy_s1) + GW'(ez_s1) + (GW'(lin[0]) <<< 1);
		g_c[1] = (GW'(by_s1) <<< 1) + GW'(dz_s1) + GW'(fx_s1) + (GW'(lin[1]) <<< 1);
		g_c[2] = (GW'(cz_s1) <<< 1) + GW'(dy_s1) + GW'(ex_s1) + (GW'(lin[2]) <<< 1);
	end

	logic signed [CW-1:0] crd_s2 [3];
	logic signed [LW-1:0] l_s2 [3];
	logic signed [GW-1:0] g_s2 [3];

	always_ff @(posedge clk) begin
		crd_s2 <= crd_s1;
		l_s2   <= l_c;
		g_s2   <= g_c;
	end

	// Stage 3: coordinate times inner sum, split in two partial products
	logic signed [LS:0]    lo_c [3];
	logic signed [HW-1:0]  hi_c [3];
	logic signed [PLW-1:0] pl_c [3];
	logic signed [PHW-1:0] ph_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lo_c[k] = {1'b0, l_s2[k][LS-1:0]};
			hi_c[k] = l_s2[k][LW-1:LS];
			pl_c[k] = crd_s2[k] * lo_c[k];
			ph_c[k] = crd_s2[k] * hi_c[k];
		end
	end

	logic signed [PLW-1:0] pl_s3 [3];
	logic signed [PHW-1:0] ph_s3 [3];
	logic signed [GW-1:0]  g_s3 [3];

	always_ff @(posedge clk) begin
		pl_s3 <= pl_c;
		ph_s3 <= ph_c;
		g_s3  <= g_s2;
	end

	// Stage 4: recombine partial products into one term per axis
	logic signed [TW-1:0] t_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			t_c[k] = (TW'(ph_s3[k]) <<< LS) + TW'(pl_s3[k]);
		end
	end

	logic signed [TW-1:0] t_s4 [3];
	logic signed [GW-1:0] g_s4 [3];

	always_ff @(posedge clk) begin
		t_s4 <= t_c;
		g_s4 <= g_s3;
	end

	// Stage 5: center value, four times the quadric at the doubled point
	logic signed [VW-1:0] v_c;

	assign v_c = VW'(t_s4[0]) + VW'(t_s4[1]) + VW'(t_s4[2]) + (VW'(cj) <<< 2);

	logic signed [VW-1:0] v_s5;
	logic signed [GW-1:0] g_s5 [3];

	always_ff @(posedge clk) begin
		v_s5 <= v_c;
		g_s5 <= g_s4;
	end

	// Stage 6: half-voxel neighbors, center plus or minus gradient plus square coef
	logic signed [NW-1:0] np_c [3];
	logic signed [NW-1:0] nm_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			np_c[k] = NW'(v_s5) + NW'(g_s5[k]) + NW'(sqc[k]);
			nm_c[k] = NW'(v_s5) - NW'(g_s5[k]) + NW'(sqc[k]);
		end
	end

	logic signed [VW-1:0] v_s6;
	logic signed [NW-1:0] np_s6 [3];
	logic signed [NW-1:0] nm_s6 [3];

	always_ff @(posedge clk) begin
		v_s6  <= v_s5;
		np_s6 <= np_c;
		nm_s6 <= nm_c;
	end

	// Stage 7: signs, zero tie rule and surface decision
	logic center_zero_c, inside_c, surf_c;
	logic negp_c [3];
	logic negm_c [3];

	always_comb begin
		center_zero_c = (v_s6 == '0);
		inside_c      = v_s6[VW-1];
		surf_c        = center_zero_c;
		for (int k = 0; k < 3; k++) begin
			negp_c[k] = np_s6[k][NW-1] | ((np_s6[k] == '0) & inside_c);
			negm_c[k] = nm_s6[k][NW-1] | ((nm_s6[k] == '0) & inside_c);
			surf_c    = surf_c | (negp_c[k] ^ negm_c[k]);
		end
	end

	logic on_surface_s7, inside_s7;

	always_ff @(posedge clk) begin
		on_surface_s7 <= surf_c;
		inside_s7     <= inside_c & ~center_zero_c;
	end

	// Drive the result strobe and payload
	assign done                 = vld_s7;
	assign result.on_surface    = on_surface_s7;
	assign result.center_inside = inside_s7;

endmodule

[rtl/qsvt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsvt_checker
// Port-level checks of request and result timing for the voxel test.
// ----------------------------------------------------------------------------
module qsvt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	import qsvt_pkg::*;

	// The evaluator takes a request in every cycle
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised on a fully pipelined evaluator");

	// Every request gives a result after the fixed latency
	a_req_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##QSVT_LATENCY done)
		else $error("request without a result at the expected cycle");

	// Every result traces back to a request
	a_done_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, QSVT_LATENCY))
		else $error("result strobe without a matching request");

endmodule

bind quadric_surface_voxel_test_top qsvt_checker u_qsvt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
